@@ rtl/sh3c_pkg.sv @@
// Shared types, constants and helpers for the 3x3 sharpening convolution unit.
// No dependencies; imported by every module under rtl/.
`timescale 1ns / 1ps

package sh3c_pkg;

  localparam int DEF_MAX_WIDTH    = 64;
  localparam int DEF_MAX_HEIGHT   = 1024;
  localparam int PIX_W            = 8;
  localparam int LINES            = 3;
  localparam int FILT_W           = 12;
  localparam int OUT_ROW_W        = 10;
  localparam int OUT_COL_W        = 6;
  localparam int OUT_TDATA_W      = 32;
  localparam int CFG_IDX_W        = 2;
  localparam int CFG_DATA_W       = 11;
  localparam int CFG_WIDTH_W      = 7;
  localparam int CFG_HEIGHT_W     = 11;
  localparam int RST_FRAME_WIDTH  = 5;
  localparam int RST_FRAME_HEIGHT = 5;
  localparam int QDEPTH           = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FRAME_WIDTH  = 2'd0,
    REG_FRAME_HEIGHT = 2'd1
  } cfg_reg_t;

  // one column of the three-line store, indexed by row modulo 3
  typedef logic [LINES-1:0][PIX_W-1:0] col_word_t;
  typedef logic [1:0] slot_t;

  typedef struct packed {
    logic up;
    logic down;
    logic left;
    logic right;
  } nbr_mask_t;

  typedef struct packed {
    logic                     frame_end;
    logic [OUT_COL_W-1:0]     col;
    logic [OUT_ROW_W-1:0]     row;
    logic signed [FILT_W-1:0] filtered;
  } result_t;

  function automatic slot_t slot_inc(slot_t s);
    return (s == 2'd2) ? 2'd0 : s + 2'd1;
  endfunction

  function automatic slot_t slot_dec(slot_t s);
    return (s == 2'd0) ? 2'd2 : s - 2'd1;
  endfunction

endpackage

@@ rtl/sharpen_3x3_convolution_unit.sv @@
// 3x3 sharpening convolution over a raster pixel stream; top level with frame control.
// Path: a result due on an accepted item passes the input register, then the output queue, to out_tvalid.
// Throughput: one request per cycle while in_tready is high (it drops as the output queue fills); the compute
// stage is one registered pass fed by a two-port line store read ahead, with a three-entry output queue.
// Reset: rst_n (synchronous) clears positions, flags, queue and sets width and height to 5;
// the line store is not cleared and needs no clearing pass.
`timescale 1ns / 1ps

module sharpen_3x3_convolution_unit import sh3c_pkg::*; #(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [PIX_W-1:0]       in_tdata,   // [7:0] pixel
  input  logic                   in_tuser,   // [0] cmd (1 = flush)
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // [11:0] filtered, [21:12] out_row, [27:22] out_col
  output logic                   out_tlast,  // frame_end
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  localparam int COL_W  = $clog2(MAX_WIDTH);
  localparam int ROW_W  = $clog2(MAX_HEIGHT);
  localparam int WCNT_W = $clog2(MAX_WIDTH + 1);
  localparam int HCNT_W = $clog2(MAX_HEIGHT + 1);
  localparam int RST_W  = (RST_FRAME_WIDTH > MAX_WIDTH) ? MAX_WIDTH : RST_FRAME_WIDTH;
  localparam int RST_H  = (RST_FRAME_HEIGHT > MAX_HEIGHT) ? MAX_HEIGHT : RST_FRAME_HEIGHT;

  logic              s1_valid_r;
  logic              s1_cmd_r;
  logic [PIX_W-1:0]  s1_pix_r;

  logic [WCNT_W-1:0] eff_w_r, eff_w_nxt;
  logic [HCNT_W-1:0] eff_h_r, eff_h_nxt;
  logic [ROW_W-1:0]  in_row_r, in_row_nxt;
  logic [COL_W-1:0]  in_col_r, in_col_nxt;
  slot_t             in_slot_r, in_slot_nxt;
  logic [ROW_W-1:0]  emit_row_r, emit_row_nxt;
  logic [COL_W-1:0]  emit_col_r, emit_col_nxt;
  slot_t             emit_slot_r, emit_slot_nxt;
  logic              all_in_r, all_in_nxt;
  logic              all_out_r, all_out_nxt;
  col_word_t         win_prev_r, win_prev_nxt;

  logic              in_acc;
  logic              cfg_acc;
  logic              is_pix;
  logic              restart;
  logic              all_in0;
  logic              all_out0;
  logic              wr_en;
  logic [WCNT_W-1:0] in_col_p1;
  logic [HCNT_W-1:0] in_row_p1;
  logic [WCNT_W-1:0] emit_col_p1;
  logic [HCNT_W-1:0] emit_row_p1;
  logic [HCNT_W-1:0] rr;
  logic [WCNT_W-1:0] cc;
  logic              ready;
  logic              last;
  logic              res_valid;
  nbr_mask_t         mask;
  logic [CFG_WIDTH_W-1:0]  cfg_w_val;
  logic [CFG_HEIGHT_W-1:0] cfg_h_val;
  logic [WCNT_W-1:0] cfg_w_eff;
  logic [HCNT_W-1:0] cfg_h_eff;

  col_word_t         cur_word;
  col_word_t         next_word;
  logic signed [FILT_W-1:0] filtered;
  result_t           res;
  result_t           head;
  logic              q_not_empty;
  logic [1:0]        q_count;

  assign cfg_ready  = 1'b1;
  assign cfg_acc    = cfg_valid & cfg_ready;
  assign in_tready  = ({1'b0, q_count} + {2'b00, s1_valid_r}) <= 3'd2;
  assign in_acc     = in_tvalid & in_tready;
  assign out_tvalid = q_not_empty;
  assign out_tdata  = OUT_TDATA_W'({head.col, head.row, head.filtered});
  assign out_tlast  = head.frame_end;

  // register value clamping: zero acts as one, oversize acts as the maximum
  always_comb begin
    cfg_w_val = cfg_data[CFG_WIDTH_W-1:0];
    cfg_h_val = cfg_data[CFG_HEIGHT_W-1:0];
    if (cfg_w_val == '0) begin
      cfg_w_eff = WCNT_W'(1);
    end else if (32'(cfg_w_val) > 32'(MAX_WIDTH)) begin
      cfg_w_eff = WCNT_W'(MAX_WIDTH);
    end else begin
      cfg_w_eff = WCNT_W'(cfg_w_val);
    end
    if (cfg_h_val == '0) begin
      cfg_h_eff = HCNT_W'(1);
    end else if (32'(cfg_h_val) > 32'(MAX_HEIGHT)) begin
      cfg_h_eff = HCNT_W'(MAX_HEIGHT);
    end else begin
      cfg_h_eff = HCNT_W'(cfg_h_val);
    end
  end

  always_comb begin
    is_pix   = s1_valid_r & ~s1_cmd_r;
    restart  = is_pix & all_in_r & all_out_r;
    all_in0  = all_in_r & ~restart;
    all_out0 = all_out_r & ~restart;
    wr_en    = is_pix & ~all_in0;

    in_col_p1   = WCNT_W'(in_col_r) + WCNT_W'(1);
    in_row_p1   = HCNT_W'(in_row_r) + HCNT_W'(1);
    in_row_nxt  = in_row_r;
    in_col_nxt  = in_col_r;
    in_slot_nxt = in_slot_r;
    all_in_nxt  = all_in0;
    if (wr_en) begin
      if (in_col_p1 >= eff_w_r) begin
        in_col_nxt = '0;
        if (in_row_p1 >= eff_h_r) begin
          all_in_nxt  = 1'b1;
          in_row_nxt  = '0;
          in_slot_nxt = '0;
        end else begin
          in_row_nxt  = in_row_p1[ROW_W-1:0];
          in_slot_nxt = slot_inc(in_slot_r);
        end
      end else begin
        in_col_nxt = in_col_p1[COL_W-1:0];
      end
    end

    emit_col_p1 = WCNT_W'(emit_col_r) + WCNT_W'(1);
    emit_row_p1 = HCNT_W'(emit_row_r) + HCNT_W'(1);
    mask.up     = (emit_row_r != '0);
    mask.down   = (emit_row_p1 < eff_h_r);
    mask.left   = (emit_col_r != '0);
    mask.right  = (emit_col_p1 < eff_w_r);
    rr = mask.down  ? emit_row_p1 : HCNT_W'(emit_row_r);
    cc = mask.right ? emit_col_p1 : WCNT_W'(emit_col_r);
    // result is due once its lower-right neighbor (clamped at the border) is in
    ready = all_in_nxt || (rr < HCNT_W'(in_row_nxt)) ||
            ((rr == HCNT_W'(in_row_nxt)) && (cc < WCNT_W'(in_col_nxt)));
    last      = ~mask.down & ~mask.right;
    res_valid = s1_valid_r & ~all_out0 & ready;

    emit_row_nxt  = emit_row_r;
    emit_col_nxt  = emit_col_r;
    emit_slot_nxt = emit_slot_r;
    all_out_nxt   = all_out0;
    win_prev_nxt  = win_prev_r;
    if (res_valid) begin
      if (last) begin
        emit_row_nxt  = '0;
        emit_col_nxt  = '0;
        emit_slot_nxt = '0;
        all_out_nxt   = 1'b1;
        win_prev_nxt  = '0;
      end else if (!mask.right) begin
        emit_row_nxt  = emit_row_p1[ROW_W-1:0];
        emit_col_nxt  = '0;
        emit_slot_nxt = slot_inc(emit_slot_r);
        win_prev_nxt  = '0;
      end else begin
        emit_col_nxt = emit_col_p1[COL_W-1:0];
        win_prev_nxt = cur_word;
      end
    end

    eff_w_nxt = eff_w_r;
    eff_h_nxt = eff_h_r;
    if (cfg_acc) begin
      case (cfg_index)
        REG_FRAME_WIDTH:  eff_w_nxt = cfg_w_eff;
        REG_FRAME_HEIGHT: eff_h_nxt = cfg_h_eff;
        default: ;
      endcase
      if (cfg_index == REG_FRAME_WIDTH || cfg_index == REG_FRAME_HEIGHT) begin
        in_row_nxt    = '0;
        in_col_nxt    = '0;
        in_slot_nxt   = '0;
        emit_row_nxt  = '0;
        emit_col_nxt  = '0;
        emit_slot_nxt = '0;
        all_in_nxt    = 1'b0;
        all_out_nxt   = 1'b0;
        win_prev_nxt  = '0;
      end
    end

    res.filtered  = filtered;
    res.row       = OUT_ROW_W'(emit_row_r);
    res.col       = OUT_COL_W'(emit_col_r);
    res.frame_end = last;
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_cmd_r <= in_tuser;
      s1_pix_r <= in_tdata;
    end
    win_prev_r <= win_prev_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      eff_w_r     <= WCNT_W'(RST_W);
      eff_h_r     <= HCNT_W'(RST_H);
      in_row_r    <= '0;
      in_col_r    <= '0;
      in_slot_r   <= '0;
      emit_row_r  <= '0;
      emit_col_r  <= '0;
      emit_slot_r <= '0;
      all_in_r    <= 1'b0;
      all_out_r   <= 1'b0;
    end else begin
      s1_valid_r  <= in_acc;
      eff_w_r     <= eff_w_nxt;
      eff_h_r     <= eff_h_nxt;
      in_row_r    <= in_row_nxt;
      in_col_r    <= in_col_nxt;
      in_slot_r   <= in_slot_nxt;
      emit_row_r  <= emit_row_nxt;
      emit_col_r  <= emit_col_nxt;
      emit_slot_r <= emit_slot_nxt;
      all_in_r    <= all_in_nxt;
      all_out_r   <= all_out_nxt;
    end
  end

  sh3c_line_buffer #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_line_buffer (
    .clk        (clk),
    .rst_n      (rst_n),
    .wr_en      (wr_en),
    .wr_col     (in_col_r),
    .wr_slot    (in_slot_r),
    .wr_data    (s1_pix_r),
    .rd_col_nxt (emit_col_nxt),
    .cur_word   (cur_word),
    .next_word  (next_word)
  );

  sh3c_kernel u_kernel (
    .prev_word (win_prev_r),
    .cur_word  (cur_word),
    .next_word (next_word),
    .slot      (emit_slot_r),
    .mask      (mask),
    .filtered  (filtered)
  );

  sh3c_out_queue u_out_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (res_valid),
    .push_data (res),
    .pop       (out_tvalid & out_tready),
    .head      (head),
    .not_empty (q_not_empty),
    .count     (q_count)
  );

endmodule

@@ rtl/sh3c_line_buffer.sv @@
// Three-line pixel store, one column word per address, two registered read ports.
// Forwards the write of the previous and the current cycle. Depends on sh3c_pkg.
`timescale 1ns / 1ps

module sh3c_line_buffer import sh3c_pkg::*; #(
  parameter int MAX_WIDTH = DEF_MAX_WIDTH,
  localparam int COL_W = $clog2(MAX_WIDTH)
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             wr_en,
  input  logic [COL_W-1:0] wr_col,
  input  slot_t            wr_slot,
  input  logic [PIX_W-1:0] wr_data,
  input  logic [COL_W-1:0] rd_col_nxt,
  output col_word_t        cur_word,
  output col_word_t        next_word
);

  col_word_t        mem [MAX_WIDTH];
  col_word_t        rd_a_r;
  col_word_t        rd_b_r;
  logic [COL_W-1:0] rd_col_r;
  logic [COL_W-1:0] rd_col1_r;
  logic [COL_W-1:0] rd_col1_nxt;
  logic             pw_valid_r;
  logic [COL_W-1:0] pw_col_r;
  slot_t            pw_slot_r;
  logic [PIX_W-1:0] pw_data_r;

  assign rd_col1_nxt = (rd_col_nxt == COL_W'(MAX_WIDTH - 1)) ? '0 : rd_col_nxt + COL_W'(1);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_col][wr_slot] <= wr_data;
    end
    rd_a_r    <= mem[rd_col_nxt];
    rd_b_r    <= mem[rd_col1_nxt];
    rd_col_r  <= rd_col_nxt;
    rd_col1_r <= rd_col1_nxt;
    pw_col_r  <= wr_col;
    pw_slot_r <= wr_slot;
    pw_data_r <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pw_valid_r <= 1'b0;
    end else begin
      pw_valid_r <= wr_en;
    end
  end

  // read data misses the write landing at the same edge and the one not yet landed; patch both in
  always_comb begin
    cur_word  = rd_a_r;
    next_word = rd_b_r;
    if (pw_valid_r && pw_col_r == rd_col_r) begin
      cur_word[pw_slot_r] = pw_data_r;
    end
    if (pw_valid_r && pw_col_r == rd_col1_r) begin
      next_word[pw_slot_r] = pw_data_r;
    end
    if (wr_en && wr_col == rd_col_r) begin
      cur_word[wr_slot] = wr_data;
    end
    if (wr_en && wr_col == rd_col1_r) begin
      next_word[wr_slot] = wr_data;
    end
  end

endmodule

@@ rtl/sh3c_kernel.sv @@
// Fixed sharpening kernel: five times the center minus the up, down, left and right neighbors, out-of-frame as zero.
// Depends on sh3c_pkg.
`timescale 1ns / 1ps

module sh3c_kernel import sh3c_pkg::*; (
  input  col_word_t                prev_word,
  input  col_word_t                cur_word,
  input  col_word_t                next_word,
  input  slot_t                    slot,
  input  nbr_mask_t                mask,
  output logic signed [FILT_W-1:0] filtered
);

  logic [PIX_W-1:0]  ctr;
  logic [PIX_W-1:0]  up;
  logic [PIX_W-1:0]  dn;
  logic [PIX_W-1:0]  lf;
  logic [PIX_W-1:0]  rt;
  logic [FILT_W-1:0] five;
  logic [FILT_W-1:0] nsum;

  always_comb begin
    ctr  = cur_word[slot];
    up   = mask.up    ? cur_word[slot_dec(slot)] : '0;
    dn   = mask.down  ? cur_word[slot_inc(slot)] : '0;
    lf   = mask.left  ? prev_word[slot]          : '0;
    rt   = mask.right ? next_word[slot]          : '0;
    five = FILT_W'({ctr, 2'b00}) + FILT_W'(ctr);
    nsum = FILT_W'(up) + FILT_W'(dn) + FILT_W'(lf) + FILT_W'(rt);
    filtered = signed'(five - nsum);
  end

endmodule

@@ rtl/sh3c_out_queue.sv @@
// Three-entry result queue between the compute stage and the output stream.
// Depends on sh3c_pkg.
`timescale 1ns / 1ps

module sh3c_out_queue import sh3c_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  input  result_t    push_data,
  input  logic       pop,
  output result_t    head,
  output logic       not_empty,
  output logic [1:0] count
);

  result_t    q_r [QDEPTH];
  logic [1:0] wr_ptr_r;
  logic [1:0] rd_ptr_r;
  logic [1:0] count_r;

  assign head      = q_r[rd_ptr_r];
  assign not_empty = (count_r != 2'd0);
  assign count     = count_r;

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == 2'(QDEPTH - 1)) ? '0 : wr_ptr_r + 2'd1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == 2'(QDEPTH - 1)) ? '0 : rd_ptr_r + 2'd1;
      end
      if (push && !pop) begin
        count_r <= count_r + 2'd1;
      end else if (pop && !push) begin
        count_r <= count_r - 2'd1;
      end
    end
  end

endmodule
